// ===== hw/rtl/vrvc_pkg.sv =====
// Shared types, codes and defaults for the voxel ray visit counter.
`timescale 1ns / 1ps
package vrvc_pkg;

    localparam int GRID_SIDE_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int IDX_MAX_W       = 8;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_TRACE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_X           = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Y           = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Z           = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_RESOLUTION = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_THRESHOLD     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OCCUPIED_THRESHOLD = 3'd5;

    localparam logic [31:0] INV_RES_RESET  = 32'd655360;
    localparam logic [15:0] OCC_THR_RESET  = 16'hFFFF;

    localparam logic [1:0] JOB_CLEAR  = 2'd0;
    localparam logic [1:0] JOB_TRACE  = 2'd1;
    localparam logic [1:0] JOB_READ   = 2'd2;
    localparam logic [1:0] JOB_REPORT = 2'd3;

    localparam logic [7:0] COST_FREE    = 8'd255;
    localparam logic [7:0] COST_BLOCKED = 8'd0;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
    } in_word_t;

    typedef struct packed {
        logic       status;
        logic [7:0] cost;
    } out_word_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 status;
        logic [IDX_MAX_W-1:0] x;
        logic [IDX_MAX_W-1:0] y;
        logic [IDX_MAX_W-1:0] z;
    } job_t;

    typedef struct packed {
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic signed [31:0] camera_z;
        logic [31:0]        inverse_resolution;
        logic [15:0]        free_threshold;
        logic [15:0]        occupied_threshold;
    } cfg_t;

endpackage

// ===== hw/rtl/vrvc_front.sv =====
// Front end: accepts command words, maps trace points to voxels, emits jobs.
`timescale 1ns / 1ps
module vrvc_front
    import vrvc_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  cfg_t     cfg,
    input  logic     hold,
    output logic     push_valid,
    input  logic     push_ready,
    output job_t     push_job
);

    localparam logic [64:0] LIMIT  = 65'(GRID_SIDE) << 32;
    localparam logic [64:0] HALF   = 65'(GRID_SIDE) << 31;
    localparam logic [64:0] ONE    = 65'(1) << 32;
    localparam logic [32:0] SIDE33 = 33'(GRID_SIDE);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIFF = 3'd1;
    localparam logic [2:0] F_LO   = 3'd2;
    localparam logic [2:0] F_HI   = 3'd3;
    localparam logic [2:0] F_EVAL = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    in_word_t    item_reg, item_next;
    job_t        job_reg, job_next;
    logic [32:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [64:0] acc_reg, acc_next;

    logic [31:0] p_sel, c_sel;
    logic [32:0] diff;
    logic [15:0] inv_half;
    logic [48:0] part;
    logic [64:0] sum_pos, diff_neg, over_neg;
    logic [32:0] idx;
    logic        miss;

    assign in_ready   = (state_reg == F_IDLE) && !hold;
    assign push_valid = (state_reg == F_PUSH);
    assign push_job   = job_reg;

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                p_sel = item_reg.point_x;
                c_sel = cfg.camera_x;
            end
            2'd1:
            begin
                p_sel = item_reg.point_y;
                c_sel = cfg.camera_y;
            end
            default:
            begin
                p_sel = item_reg.point_z;
                c_sel = cfg.camera_z;
            end
        endcase
    end

    assign diff     = {p_sel[31], p_sel} - {c_sel[31], c_sel};
    assign inv_half = (state_reg == F_HI) ? cfg.inverse_resolution[31:16]
                                          : cfg.inverse_resolution[15:0];
    assign part     = mag_reg * inv_half;
    assign sum_pos  = acc_reg + HALF;
    assign diff_neg = HALF - acc_reg;
    assign over_neg = acc_reg - HALF;

    always_comb
    begin
        if (!neg_reg)
        begin
            idx  = sum_pos[64:32];
            miss = (acc_reg >= LIMIT) || (sum_pos[64:32] >= SIDE33);
        end
        else if (acc_reg <= HALF)
        begin
            idx  = diff_neg[64:32];
            miss = 1'b0;
        end
        else
        begin
            idx  = '0;
            miss = (over_neg >= ONE);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        item_next  = item_reg;
        job_next   = job_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && !hold)
                begin
                    item_next       = in_word;
                    axis_next       = 2'd0;
                    job_next.status = 1'b0;
                    job_next.x      = IDX_MAX_W'(in_word.cell_x);
                    job_next.y      = IDX_MAX_W'(in_word.cell_y);
                    job_next.z      = IDX_MAX_W'(in_word.cell_z);
                    state_next      = F_PUSH;
                    case (in_word.command)
                        CMD_CLEAR:
                            job_next.kind = JOB_CLEAR;
                        CMD_TRACE:
                        begin
                            job_next.kind = JOB_TRACE;
                            state_next    = F_DIFF;
                        end
                        CMD_READ:
                        begin
                            if (32'(in_word.cell_x) < 32'(GRID_SIDE)
                                && 32'(in_word.cell_y) < 32'(GRID_SIDE)
                                && 32'(in_word.cell_z) < 32'(GRID_SIDE))
                                job_next.kind = JOB_READ;
                            else
                                job_next.kind = JOB_REPORT;
                        end
                        default:
                            job_next.kind = JOB_REPORT;
                    endcase
                end
            end
            F_DIFF:
            begin
                neg_next   = diff[32];
                mag_next   = diff[32] ? (~diff + 33'd1) : diff;
                state_next = F_LO;
            end
            F_LO:
            begin
                acc_next   = 65'(part);
                state_next = F_HI;
            end
            F_HI:
            begin
                acc_next   = acc_reg + (65'(part) << 16);
                state_next = F_EVAL;
            end
            F_EVAL:
            begin
                if (miss)
                begin
                    job_next.kind   = JOB_REPORT;
                    job_next.status = 1'b1;
                    state_next      = F_PUSH;
                end
                else
                begin
                    case (axis_reg)
                        2'd0:    job_next.x = IDX_MAX_W'(idx);
                        2'd1:    job_next.y = IDX_MAX_W'(idx);
                        default: job_next.z = IDX_MAX_W'(idx);
                    endcase
                    if (axis_reg == 2'd2)
                        state_next = F_PUSH;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = F_DIFF;
                    end
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        axis_reg <= axis_next;
        item_reg <= item_next;
        job_reg  <= job_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
    end

endmodule

// ===== hw/rtl/vrvc_queue.sv =====
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
module vrvc_queue
    import vrvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t       slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next    = do_push ? ~wr_reg : wr_reg;
        rd_next    = do_pop ? ~rd_reg : rd_reg;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

// ===== hw/rtl/vrvc_back.sv =====
// Back end: counter memory, clear sweep, Bresenham walk and cost readout.
`timescale 1ns / 1ps
module vrvc_back
    import vrvc_pkg::*;
#(
    parameter int GRID_SIDE   = GRID_SIDE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  job_t      pop_job,
    input  cfg_t      cfg,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word,
    output logic      init_busy
);

    localparam int IW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = COUNT_WIDTH;
    localparam int EW    = IW + 3;
    localparam logic [IW-1:0] CENTRE    = IW'(GRID_SIDE / 2);
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [3:0] B_INIT      = 4'd0;
    localparam logic [3:0] B_IDLE      = 4'd1;
    localparam logic [3:0] B_CLEAR     = 4'd2;
    localparam logic [3:0] B_OCC_RD    = 4'd3;
    localparam logic [3:0] B_OCC_WR    = 4'd4;
    localparam logic [3:0] B_SETUP     = 4'd5;
    localparam logic [3:0] B_WALK_RD   = 4'd6;
    localparam logic [3:0] B_WALK_WR   = 4'd7;
    localparam logic [3:0] B_READ_RD   = 4'd8;
    localparam logic [3:0] B_READ_EVAL = 4'd9;
    localparam logic [3:0] B_DIV       = 4'd10;
    localparam logic [3:0] B_DONE      = 4'd11;

    logic [2*CW-1:0] mem [DEPTH];
    logic [2*CW-1:0] rdata_reg;
    logic            mem_we;
    logic [2*CW-1:0] mem_wdata;

    logic [3:0]     state_reg, state_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [CW-1:0]  max_reg, max_next;
    logic           out_valid_reg, out_valid_next;
    out_word_t      out_word_reg, out_word_next;
    out_word_t      res_reg, res_next;

    logic [IW-1:0]        tgt_reg [3];
    logic [IW-1:0]        tgt_next [3];
    logic [IW-1:0]        p_reg [3];
    logic [IW-1:0]        p_next [3];
    logic [IW-1:0]        abs_reg [3];
    logic [IW-1:0]        abs_next [3];
    logic                 neg_reg [3];
    logic                 neg_next [3];
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] e_next [3];
    logic [1:0]           major_reg, major_next;
    logic [IW-1:0]        cnt_reg, cnt_next;

    logic [CW-1:0] rem_reg, rem_next;
    logic [7:0]    low_reg, low_next;
    logic [7:0]    quo_reg, quo_next;
    logic [2:0]    div_cnt_reg, div_cnt_next;

    logic [IW-1:0]        abs_c [3];
    logic                 neg_c [3];
    logic [1:0]           major_c;
    logic [IW-1:0]        adv_p [3];
    logic signed [EW-1:0] adv_e [3];
    logic signed [EW-1:0] two_am;
    logic [CW-1:0]        v_cur, occ_cur, v_inc, occ_inc;
    logic [CW-1:0]        span;
    logic [CW+7:0]        num;
    logic [CW:0]          trial;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] x,
                                              input logic [IW-1:0] y,
                                              input logic [IW-1:0] z);
        return AW'(x) * AW'(GRID_SIDE * GRID_SIDE) + AW'(y) * AW'(GRID_SIDE) + AW'(z);
    endfunction

    assign pop_ready = (state_reg == B_IDLE);
    assign init_busy = (state_reg == B_INIT);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign v_cur   = rdata_reg[CW-1:0];
    assign occ_cur = rdata_reg[2*CW-1:CW];
    assign v_inc   = (v_cur == COUNT_MAX) ? v_cur : v_cur + CW'(1);
    assign occ_inc = (occ_cur == COUNT_MAX) ? occ_cur : occ_cur + CW'(1);
    assign span    = max_reg - v_cur;
    assign num     = ({span, 8'd0}) - (CW + 8)'(span);
    assign trial   = {rem_reg, low_reg[7]};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_c[i] = (tgt_reg[i] < CENTRE);
            abs_c[i] = neg_c[i] ? (CENTRE - tgt_reg[i]) : (tgt_reg[i] - CENTRE);
        end
        if (abs_c[0] >= abs_c[1] && abs_c[0] >= abs_c[2])
            major_c = 2'd0;
        else if (abs_c[1] >= abs_c[0] && abs_c[1] >= abs_c[2])
            major_c = 2'd1;
        else
            major_c = 2'd2;
    end

    assign two_am = EW'({abs_reg[major_reg], 1'b0});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            adv_p[i] = p_reg[i];
            adv_e[i] = e_reg[i] + EW'({abs_reg[i], 1'b0});
            if (2'(i) == major_reg)
                adv_p[i] = neg_reg[i] ? p_reg[i] - IW'(1) : p_reg[i] + IW'(1);
            else if (!e_reg[i][EW-1] && e_reg[i] != '0)
            begin
                adv_p[i] = neg_reg[i] ? p_reg[i] - IW'(1) : p_reg[i] + IW'(1);
                adv_e[i] = e_reg[i] - two_am + EW'({abs_reg[i], 1'b0});
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        case (state_reg)
            B_INIT, B_CLEAR:
                mem_we = 1'b1;
            B_OCC_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {occ_inc, v_cur};
            end
            B_WALK_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {occ_cur, v_inc};
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        res_next       = res_reg;
        tgt_next       = tgt_reg;
        p_next         = p_reg;
        abs_next       = abs_reg;
        neg_next       = neg_reg;
        e_next         = e_reg;
        major_next     = major_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    max_next   = '0;
                    state_next = (state_reg == B_INIT) ? B_IDLE : B_DONE;
                end
                else
                    addr_next = addr_reg + AW'(1);
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    res_next.status = pop_job.status;
                    res_next.cost   = COST_BLOCKED;
                    tgt_next[0]     = IW'(pop_job.x);
                    tgt_next[1]     = IW'(pop_job.y);
                    tgt_next[2]     = IW'(pop_job.z);
                    addr_next       = addr_of(IW'(pop_job.x), IW'(pop_job.y),
                                              IW'(pop_job.z));
                    case (pop_job.kind)
                        JOB_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = B_CLEAR;
                        end
                        JOB_TRACE:
                            state_next = B_OCC_RD;
                        JOB_READ:
                            state_next = B_READ_RD;
                        default:
                            state_next = B_DONE;
                    endcase
                end
            end
            B_OCC_RD:
                state_next = B_OCC_WR;
            B_OCC_WR:
                state_next = B_SETUP;
            B_SETUP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_next[i]   = CENTRE;
                    abs_next[i] = abs_c[i];
                    neg_next[i] = neg_c[i];
                    e_next[i]   = EW'({abs_c[i], 1'b0}) - EW'(abs_c[major_c]);
                end
                major_next = major_c;
                cnt_next   = abs_c[major_c];
                addr_next  = addr_of(CENTRE, CENTRE, CENTRE);
                state_next = B_WALK_RD;
            end
            B_WALK_RD:
                state_next = B_WALK_WR;
            B_WALK_WR:
            begin
                if (v_inc > max_reg)
                    max_next = v_inc;
                if (cnt_reg == '0)
                    state_next = B_DONE;
                else
                begin
                    p_next     = adv_p;
                    e_next     = adv_e;
                    cnt_next   = cnt_reg - IW'(1);
                    addr_next  = addr_of(adv_p[0], adv_p[1], adv_p[2]);
                    state_next = B_WALK_RD;
                end
            end
            B_READ_RD:
                state_next = B_READ_EVAL;
            B_READ_EVAL:
            begin
                state_next = B_DONE;
                if (occ_cur != '0)
                    res_next.cost = COST_BLOCKED;
                else if (32'(v_cur) <= 32'(cfg.free_threshold))
                    res_next.cost = COST_FREE;
                else if (32'(v_cur) > 32'(cfg.occupied_threshold))
                    res_next.cost = COST_BLOCKED;
                else if (max_reg == '0 || v_cur > max_reg)
                    res_next.cost = COST_BLOCKED;
                else
                begin
                    rem_next     = num[CW+7:8];
                    low_next     = num[7:0];
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = B_DIV;
                end
            end
            B_DIV:
            begin
                low_next = {low_reg[6:0], 1'b0};
                if (trial >= {1'b0, max_reg})
                begin
                    rem_next = CW'(trial - {1'b0, max_reg});
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd7)
                begin
                    res_next.cost = quo_next;
                    state_next    = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            addr_reg      <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        res_reg      <= res_next;
        tgt_reg      <= tgt_next;
        p_reg        <= p_next;
        abs_reg      <= abs_next;
        neg_reg      <= neg_next;
        e_reg        <= e_next;
        major_reg    <= major_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        low_reg      <= low_next;
        quo_reg      <= quo_next;
        div_cnt_reg  <= div_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
        rdata_reg <= mem[addr_reg];
    end

endmodule

// ===== hw/rtl/voxel_ray_visit_counter_top.sv =====
// Top level of the voxel ray visit counter: config registers, front, queue, back.
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_ready  | in_word (command, point, cell)
//  out     | out_valid / out_ready| out_word (status, cost)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Reset clears every counter with a sweep over all GRID_SIDE^3 cells (32768 by default);
// in_ready stays low until it ends. A clear command takes the same sweep.
// Trace: point mapping splits each axis product into two 33x16 multiplies, then the counter
// memory updates the end cell and each cell of a walk of n steps (read-modify-write).
// Read: a read and an evaluation of the cell, plus 8 divider steps when the cost is scaled.
// A two-word job queue and the output register let either side stall alone.
`timescale 1ns / 1ps
module voxel_ray_visit_counter_top
    import vrvc_pkg::*;
#(
    parameter int GRID_SIDE   = GRID_SIDE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    cfg_t cfg_reg;
    logic init_busy;
    logic push_valid, push_ready, pop_valid, pop_ready;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x           <= '0;
            cfg_reg.camera_y           <= '0;
            cfg_reg.camera_z           <= '0;
            cfg_reg.inverse_resolution <= INV_RES_RESET;
            cfg_reg.free_threshold     <= '0;
            cfg_reg.occupied_threshold <= OCC_THR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAMERA_X:           cfg_reg.camera_x           <= cfg_data;
                REG_CAMERA_Y:           cfg_reg.camera_y           <= cfg_data;
                REG_CAMERA_Z:           cfg_reg.camera_z           <= cfg_data;
                REG_INVERSE_RESOLUTION: cfg_reg.inverse_resolution <= cfg_data;
                REG_FREE_THRESHOLD:     cfg_reg.free_threshold     <= cfg_data[15:0];
                REG_OCCUPIED_THRESHOLD: cfg_reg.occupied_threshold <= cfg_data[15:0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    vrvc_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .cfg        (cfg_reg),
        .hold       (init_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    vrvc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    vrvc_back #(
        .GRID_SIDE   (GRID_SIDE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .init_busy (init_busy)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the voxel ray visit counter: directed table, then random phases vs a predictor.
`timescale 1ns / 1ps
module testbench;
    import vrvc_pkg::*;

    localparam int SIDE  = GRID_SIDE_DEF;
    localparam int CELLS = SIDE * SIDE * SIDE;
    localparam int unsigned CNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t res;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_word_t               in_word = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    bit        quiet = 1'b0;
    bit        typed_on = 1'b0;
    out_word_t typed_val = '0;

    logic signed [31:0] cam_x, cam_y, cam_z;
    logic [31:0]        inv_res;
    logic [15:0]        free_thr, occ_thr;
    int unsigned        visits [CELLS];
    int unsigned        occupied [CELLS];
    int unsigned        max_visits;

    out_word_t pending_costs[$];
    row_t      table_rows[$];
    int        mismatches = 0;
    int        n_trace = 0, n_read = 0, n_outside = 0, n_clear = 0;

    voxel_ray_visit_counter_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int axis_voxel(logic signed [31:0] p, logic signed [31:0] cam);
        longint      d;
        logic [63:0] mag, m, h;
        d = longint'(p) - longint'(cam);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        m = mag * {32'd0, inv_res};
        h = 64'(SIDE) << 31;
        if (d >= 0)
        begin
            if (m >= (64'(SIDE) << 32))
                return -1;
            if (((m + h) >> 32) >= 64'(SIDE))
                return -1;
            return int'((m + h) >> 32);
        end
        if (m <= h)
            return int'((h - m) >> 32);
        if (m - h < (64'd1 << 32))
            return 0;
        return -1;
    endfunction

    function automatic void bump_visit(int x, int y, int z);
        int i;
        if (x < 0 || y < 0 || z < 0 || x >= SIDE || y >= SIDE || z >= SIDE)
            return;
        i = (x * SIDE + y) * SIDE + z;
        if (visits[i] < CNT_MAX)
            visits[i]++;
        if (visits[i] > max_visits)
            max_visits = visits[i];
    endfunction

    function automatic void walk_line(int x2, int y2, int z2);
        int c, dx, dy, dz, sx, sy, sz, l, m, n, e1, e2;
        int p [3];
        c = SIDE / 2;
        dx = x2 - c; dy = y2 - c; dz = z2 - c;
        sx = dx < 0 ? -1 : 1; sy = dy < 0 ? -1 : 1; sz = dz < 0 ? -1 : 1;
        l = dx < 0 ? -dx : dx; m = dy < 0 ? -dy : dy; n = dz < 0 ? -dz : dz;
        p[0] = c; p[1] = c; p[2] = c;
        if (l >= m && l >= n)
        begin
            e1 = 2 * m - l; e2 = 2 * n - l;
            for (int k = 0; k < l; k++)
            begin
                bump_visit(p[0], p[1], p[2]);
                if (e1 > 0) begin p[1] += sy; e1 -= 2 * l; end
                if (e2 > 0) begin p[2] += sz; e2 -= 2 * l; end
                e1 += 2 * m; e2 += 2 * n; p[0] += sx;
            end
        end
        else if (m >= l && m >= n)
        begin
            e1 = 2 * l - m; e2 = 2 * n - m;
            for (int k = 0; k < m; k++)
            begin
                bump_visit(p[0], p[1], p[2]);
                if (e1 > 0) begin p[0] += sx; e1 -= 2 * m; end
                if (e2 > 0) begin p[2] += sz; e2 -= 2 * m; end
                e1 += 2 * l; e2 += 2 * n; p[1] += sy;
            end
        end
        else
        begin
            e1 = 2 * m - n; e2 = 2 * l - n;
            for (int k = 0; k < n; k++)
            begin
                bump_visit(p[0], p[1], p[2]);
                if (e1 > 0) begin p[1] += sy; e1 -= 2 * n; end
                if (e2 > 0) begin p[0] += sx; e2 -= 2 * n; end
                e1 += 2 * m; e2 += 2 * l; p[2] += sz;
            end
        end
        bump_visit(p[0], p[1], p[2]);
    endfunction

    function automatic logic [7:0] cell_cost(int x, int y, int z);
        int          i;
        int unsigned v;
        i = (x * SIDE + y) * SIDE + z;
        v = visits[i];
        if (occupied[i] != 0)
            return COST_BLOCKED;
        if (v <= free_thr)
            return COST_FREE;
        if (v > occ_thr || max_visits == 0 || v > max_visits)
            return COST_BLOCKED;
        return 8'((longint'(max_visits - v) * 255) / max_visits);
    endfunction

    function automatic void clear_counts();
        foreach (visits[i])
        begin
            visits[i] = 0;
            occupied[i] = 0;
        end
        max_visits = 0;
    endfunction

    function automatic out_word_t predict_word(in_word_t w);
        out_word_t r;
        int        x, y, z, i;
        r = '0;
        case (w.command)
            CMD_CLEAR: clear_counts();
            CMD_TRACE:
            begin
                x = axis_voxel(w.point_x, cam_x);
                y = axis_voxel(w.point_y, cam_y);
                z = axis_voxel(w.point_z, cam_z);
                if (x < 0 || y < 0 || z < 0)
                    r.status = 1'b1;
                else
                begin
                    i = (x * SIDE + y) * SIDE + z;
                    if (occupied[i] < CNT_MAX)
                        occupied[i]++;
                    walk_line(x, y, z);
                end
            end
            CMD_READ: r.cost = cell_cost(w.cell_x, w.cell_y, w.cell_z);
            default: ;
        endcase
        return r;
    endfunction

    function automatic void store_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
        case (idx)
            REG_CAMERA_X:           cam_x = d;
            REG_CAMERA_Y:           cam_y = d;
            REG_CAMERA_Z:           cam_z = d;
            REG_INVERSE_RESOLUTION: inv_res = d;
            REG_FREE_THRESHOLD:     free_thr = d[15:0];
            REG_OCCUPIED_THRESHOLD: occ_thr = d[15:0];
            default: ;
        endcase
    endfunction

    always @(negedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 29);

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && cfg_valid && cfg_ready)
            store_reg(cfg_index, cfg_data);
        if (rst_n && in_valid && in_ready)
        begin
            want = predict_word(in_word);
            pending_costs.insert(pending_costs.size(), typed_on ? typed_val : want);
            case (in_word.command)
                CMD_CLEAR: n_clear++;
                CMD_TRACE: begin n_trace++; n_outside += want.status; end
                CMD_READ:  n_read++;
                default: ;
            endcase
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_costs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d cost %0d",
                             out_word.status, out_word.cost);
            end
            else
            begin
                want = pending_costs.pop_front();
                if (out_word.status !== want.status || out_word.cost !== want.cost)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d cost %0d, got status %0d cost %0d",
                                 want.status, want.cost, out_word.status, out_word.cost);
                end
            end
        end
    end

    task automatic send_word(in_word_t w, bit typed, out_word_t res);
        while (!quiet && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        typed_on <= typed;
        typed_val <= res;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_word_t mk(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                                    logic [31:0] pz, logic [4:0] cx, logic [4:0] cy,
                                    logic [4:0] cz);
        in_word_t w;
        w.command = cmd;
        w.point_x = px; w.point_y = py; w.point_z = pz;
        w.cell_x = cx; w.cell_y = cy; w.cell_z = cz;
        return w;
    endfunction

    function automatic void add_row(in_word_t w, bit typed = 0, bit st = 0, logic [7:0] c = 0);
        row_t r;
        r.w = w;
        r.typed = typed;
        r.res.status = st;
        r.res.cost = c;
        table_rows.insert(table_rows.size(), r);
    endfunction

    function automatic logic [31:0] aim(logic signed [31:0] cam);
        longint t, num, off;
        t = longint'($urandom_range(35)) - 18;
        num = t * 64'sh1_0000_0000 + longint'($urandom);
        if (inv_res == 0)
            off = longint'($signed($urandom));
        else
            off = num / longint'({32'd0, inv_res});
        return 32'(longint'(cam) + off);
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        w = mk(2'($urandom), $urandom, $urandom, $urandom,
               5'($urandom), 5'($urandom), 5'($urandom));
        pick = $urandom_range(99);
        if (pick < 58)
        begin
            w.command = CMD_TRACE;
            w.point_x = aim(cam_x);
            w.point_y = aim(cam_y);
            w.point_z = aim(cam_z);
        end
        else if (pick < 92)
        begin
            w.command = CMD_READ;
            if (pick < 86)
            begin
                w.cell_x = 5'($urandom_range(20, 11));
                w.cell_y = 5'($urandom_range(20, 11));
                w.cell_z = 5'($urandom_range(20, 11));
            end
        end
        else if (w.command == CMD_CLEAR)
            w.command = CMD_READ;
        return w;
    endfunction

    initial
    begin
        logic [31:0] phase_regs [6][6];
        logic [31:0] one_m, cam_r;

        cam_x = 0; cam_y = 0; cam_z = 0;
        inv_res = INV_RES_RESET; free_thr = 0; occ_thr = OCC_THR_RESET;
        clear_counts();
        one_m = 32'd65536;
        cam_r = $urandom_range(300000) - 150000;
        phase_regs[0] = '{0, 0, 0, INV_RES_RESET, 0, OCC_THR_RESET};
        phase_regs[1] = '{cam_r, -cam_r, 32'd1000, INV_RES_RESET, 1, 6};
        phase_regs[2] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0, 0};
        phase_regs[3] = '{32'h7FFF_FFFF, 32'h8000_0000, $urandom, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
        phase_regs[4] = '{$urandom, $urandom, $urandom, 0, 3, 20};
        phase_regs[5] = '{$urandom, $urandom, $urandom, 32'd2621440, 2, 100};

        add_row(mk(CMD_READ, 0, 0, 0, 0, 0, 0), 1, 0, COST_FREE);
        add_row(mk(CMD_READ, 0, 0, 0, 31, 31, 31), 1, 0, COST_FREE);
        add_row(mk(CMD_TRACE, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk(CMD_READ, 0, 0, 0, 16, 16, 16), 1, 0, COST_BLOCKED);
        add_row(mk(CMD_TRACE, 32'd98304, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk(CMD_TRACE, 32'd104858, 0, 0, 0, 0, 0), 1, 1, 0);
        add_row(mk(CMD_TRACE, -32'sd104858, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk(CMD_TRACE, -32'sd111412, 0, 0, 0, 0, 0), 1, 1, 0);
        add_row(mk(CMD_TRACE, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 1, 1, 0);
        add_row(mk(CMD_TRACE, 0, 32'h8000_0000, 0, 0, 0, 0), 1, 1, 0);
        add_row(mk(CMD_TRACE, 0, 0, 32'h7FFF_FFFF, 0, 0, 0), 1, 1, 0);
        add_row(mk(CMD_TRACE, 0, 0, 32'h8000_0000, 0, 0, 0), 1, 1, 0);
        add_row(mk(CMD_TRACE, 32'd78643, -32'sd85197, 32'd45875, 0, 0, 0));
        add_row(mk(CMD_TRACE, -32'sd98304, -32'sd98304, -32'sd98304, 0, 0, 0));
        add_row(mk(CMD_READ, 0, 0, 0, 31, 16, 16), 1, 0, COST_BLOCKED);
        add_row(mk(CMD_READ, 0, 0, 0, 20, 16, 16));
        add_row(mk(CMD_READ, 0, 0, 0, 17, 15, 16));
        add_row(mk(CMD_READ, 0, 0, 0, 15, 15, 15));
        add_row(mk(CMD_READ, 0, 0, 0, 5'h15, 5'h0A, 5'h1F));
        add_row(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 31, 31), 1, 0, 0);
        add_row(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 1, 0, 0);
        add_row(mk(CMD_READ, 0, 0, 0, 16, 16, 16), 1, 0, COST_FREE);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
            send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].res);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(r[CFG_INDEX_W-1:0], phase_regs[ph][r]);
            cfg_valid <= 1'b0;
            if (ph == 1 || ph == 4)
                send_word(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);
            quiet = (ph == 2);
            for (int n = 0; n < 213; n++)
                send_word(random_word(), 0, '0);
            drain();
            quiet = 1'b0;
        end

        $display("traced %0d points (%0d outside), read %0d cells, %0d clears, six register settings",
                 n_trace, n_outside, n_read, n_clear);
        if (mismatches == 0 && pending_costs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/vrvc_pkg.sv
hw/rtl/vrvc_front.sv
hw/rtl/vrvc_queue.sv
hw/rtl/vrvc_back.sv
hw/rtl/voxel_ray_visit_counter_top.sv
tb/sv/testbench.sv
